[rtl/tolerance_box_point_lookup_unit_defines.svh]
// assertion macros for the tolerance box point lookup unit
`ifndef TOLERANCE_BOX_POINT_LOOKUP_UNIT_DEFINES_SVH
`define TOLERANCE_BOX_POINT_LOOKUP_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TBPL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TBPL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tbpl_pkg.sv]
// ---------------------------------------------------------------------------
// tbpl_pkg
// shared types and constants of the tolerance box point lookup unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tbpl_pkg;
  localparam int ENTRIES = 64;
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NONE  = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        h;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_FIND, S_INS_SHIFT, S_REM, S_QRY, S_DONE
  } state_t;

  // memory port bundle from sequencer to store
  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
  } mem_req_t;
endpackage
`default_nettype wire

[rtl/tolerance_box_point_lookup_unit.sv]
// Ordered 2-D point table with tolerance-box query. Work per item grows with
// the entries held, set by the one-read-per-cycle scan and read-then-write
// shift of the single entry memory. Results appear at most one per cycle, each
// for one cycle on strobe, and cannot be held off; busy stays high until the
// last is out, but a full-table insert is answered from idle with busy low.
// ---------------------------------------------------------------------------
// tolerance_box_point_lookup_unit
// top level: tolerance register, sequencer and entry memory
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tolerance_box_point_lookup_unit_defines.svh"
module tolerance_box_point_lookup_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  input  wire logic [31:0]        handle,
  input  wire logic               cfg_we,
  input  wire logic [30:0]        cfg_data,
  output logic                    strobe,
  output logic [31:0]             found_handle,
  output logic [1:0]              status,
  output logic                    last
);
  import tbpl_pkg::*;

  logic [30:0] tolerance;
  mem_req_t    req;
  entry_t      rd_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) tolerance <= '0;
    else if (cfg_we) tolerance <= cfg_data;
  end

  tbpl_seq u_seq (
    .clk, .rst, .start, .command, .coord_x, .coord_y, .handle,
    .tol(tolerance), .rd_data, .req, .busy, .strobe, .found_handle,
    .status, .last
  );

  tbpl_store u_store (.clk, .req, .rd_data);

  // checks
  `TBPL_ASSERT_IMP(a_no_rw_clash, req.wr_en && req.rd_en, 1'b0, "read and write together")
  `TBPL_ASSERT_IMP(a_handle_zero, strobe && status != ST_OK, found_handle == 32'd0, "handle on non-ok")
  `TBPL_ASSERT_NXT(a_busy_after_scan, start && !busy && (command == CMD_REMOVE || command == CMD_QUERY), busy, "scan not started")
endmodule
`default_nettype wire

[rtl/tbpl_store.sv]
// ---------------------------------------------------------------------------
// tbpl_store
// entry memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tbpl_store (
  input  wire logic             clk,
  input  wire tbpl_pkg::mem_req_t req,
  output tbpl_pkg::entry_t      rd_data
);
  import tbpl_pkg::*;

  entry_t mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end
endmodule
`default_nettype wire

[rtl/tbpl_seq.sv]
// ---------------------------------------------------------------------------
// tbpl_seq
// command sequencer: scans, shifts and patches the ordered table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tbpl_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire tbpl_pkg::cmd_t     command,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_y,
  input  wire logic [31:0]        handle,
  input  wire logic [30:0]        tol,
  input  wire tbpl_pkg::entry_t   rd_data,
  output tbpl_pkg::mem_req_t      req,
  output logic                    busy,
  output logic                    strobe,
  output logic [31:0]             found_handle,
  output tbpl_pkg::status_t       status,
  output logic                    last
);
  import tbpl_pkg::*;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;      // address being read
  logic          rvalid, rvalid_next; // rd_data belongs to idx-1
  logic [AW-1:0] pos, pos_next;
  entry_t        cur;
  // pending query match held one step so last can be known
  logic          pend, pend_next;
  logic [31:0]   pend_h, pend_h_next;

  logic          out_v, out_l;
  logic [31:0]   out_h;
  status_t       out_s;

  // window compare on 33-bit differences
  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic               in_box, gt_key, eq_key;

  always_comb begin
    dx = 33'(rd_data.x) - 33'(cur.x);
    dy = 33'(rd_data.y) - 33'(cur.y);
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    in_box = (ax <= {2'b00, tol}) && (ay <= {2'b00, tol});
    eq_key = (rd_data.x == cur.x) && (rd_data.y == cur.y);
    gt_key = (rd_data.x > cur.x) || ((rd_data.x == cur.x) && (rd_data.y > cur.y));
  end

  // state and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rvalid <= 1'b0;
      pend <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rvalid <= rvalid_next;
      pend <= pend_next;
      strobe <= out_v;
    end
    idx <= idx_next;
    pos <= pos_next;
    pend_h <= pend_h_next;
    found_handle <= out_h;
    status <= out_s;
    last <= out_l;
    if (start && !busy) begin
      cur.x <= coord_x;
      cur.y <= coord_y;
      cur.h <= handle;
    end
  end

  // next state, memory requests and results
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    rvalid_next = 1'b0;
    pos_next = pos;
    pend_next = pend;
    pend_h_next = pend_h;
    req = '0;
    out_v = 1'b0;
    out_h = '0;
    out_s = ST_OK;
    out_l = 1'b1;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        idx_next = '0;
        pend_next = 1'b0;
        if (start) begin
          case (command)
            CMD_INSERT: begin
              if (count >= CW'(ENTRIES)) begin
                out_v = 1'b1;
                out_s = ST_FULL;
              end else begin
                pos_next = count[AW-1:0];
                state_next = S_INS_FIND;
              end
            end
            CMD_REMOVE: state_next = S_REM;
            CMD_QUERY:  state_next = S_QRY;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      // find insertion point: first entry greater than the new key
      S_INS_FIND: begin
        if (rvalid && gt_key) begin
          pos_next = AW'(idx - 1'b1);
          idx_next = count;
          state_next = S_INS_SHIFT;
        end else if (idx < count) begin
          req.rd_en = 1'b1;
          req.rd_addr = idx[AW-1:0];
          idx_next = idx + 1'b1;
          rvalid_next = 1'b1;
        end else begin
          idx_next = count;
          state_next = S_INS_SHIFT;
        end
      end
      // move entries up one slot from the top down, then place the new one
      S_INS_SHIFT: begin
        if (rvalid) begin
          req.wr_en = 1'b1;
          req.wr_addr = idx[AW-1:0];
          req.wr_data = rd_data;
          idx_next = idx - 1'b1;
        end else if (idx > CW'(pos)) begin
          req.rd_en = 1'b1;
          req.rd_addr = AW'(idx - 1'b1);
          rvalid_next = 1'b1;
        end else begin
          req.wr_en = 1'b1;
          req.wr_addr = pos;
          req.wr_data = cur;
          count_next = count + 1'b1;
          out_v = 1'b1;
          state_next = S_DONE;
        end
      end
      // exact match clears the handle
      S_REM: begin
        if (rvalid && eq_key && rd_data.h == cur.h) begin
          req.wr_en = 1'b1;
          req.wr_addr = AW'(idx - 1'b1);
          req.wr_data = '{x: rd_data.x, y: rd_data.y, h: 32'd0};
          out_v = 1'b1;
          state_next = S_DONE;
        end else if (idx < count) begin
          req.rd_en = 1'b1;
          req.rd_addr = idx[AW-1:0];
          idx_next = idx + 1'b1;
          rvalid_next = 1'b1;
        end else begin
          out_v = 1'b1;
          out_s = ST_NONE;
          state_next = S_DONE;
        end
      end
      // scan, emitting each match one step late so last is known
      S_QRY: begin
        if (rvalid && rd_data.h != 32'd0 && in_box) begin
          if (pend) begin
            out_v = 1'b1;
            out_h = pend_h;
            out_l = 1'b0;
          end
          pend_next = 1'b1;
          pend_h_next = rd_data.h;
        end
        if (idx < count) begin
          req.rd_en = 1'b1;
          req.rd_addr = idx[AW-1:0];
          idx_next = idx + 1'b1;
          rvalid_next = 1'b1;
        end else if (!rvalid) begin
          out_v = 1'b1;
          state_next = S_DONE;
          if (pend) out_h = pend_h;
          else out_s = ST_NONE;
        end
      end
      // gap state so the registered strobe settles before the next item
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[test/tolerance_box_point_lookup_unit_tb.sv]
// ---------------------------------------------------------------------------
// tolerance_box_point_lookup_unit_tb
// checks the ordered point table against a behavioral table model: inserts,
// removes and box queries with random gaps, several tolerance settings
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tolerance_box_point_lookup_unit_tb;
  import tbpl_pkg::*;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        h;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] h;
    logic [1:0]  st;
    logic        lst;
  } answer_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 2000000;

  logic clk, rst, start, cfg_we;
  logic [1:0] command;
  logic signed [31:0] coord_x, coord_y;
  logic [31:0] handle;
  logic [30:0] cfg_data;
  wire busy, strobe, last;
  wire [31:0] found_handle;
  wire [1:0] status;

  tolerance_box_point_lookup_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .coord_x(coord_x), .coord_y(coord_y), .handle(handle), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .strobe(strobe), .found_handle(found_handle),
    .status(status), .last(last)
  );

  // predictor state
  entry_t    table_m [ENTRIES];
  int        fill;
  logic [30:0] tol;
  cmd_item_t pending_items[$];
  answer_t   expected_answers[$];
  int        errors = 0;
  int        cycles = 0;
  int        gap = 0;
  logic      driver_on = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // append an item to the driver queue
  task automatic queue_item(input cmd_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // append one expected result
  task automatic expect_answer(input answer_t a);
    expected_answers.insert(expected_answers.size(), a);
  endtask

  function automatic logic near(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d <= longint'({1'b0, tol});
  endfunction

  // works out the answers of one accepted item and updates the table
  task automatic predict_lookup(input cmd_item_t it);
    int pos;
    int n;
    n = 0;
    pos = fill;
    case (it.cmd)
      CMD_INSERT: begin
        if (fill >= ENTRIES) begin
          expect_answer('{0, ST_FULL, 1'b1});
        end else begin
          for (int i = 0; i < fill; i++)
            if (table_m[i].x > it.x || (table_m[i].x == it.x && table_m[i].y > it.y)) begin
              pos = i;
              break;
            end
          for (int i = fill; i > pos; i--) table_m[i] = table_m[i-1];
          table_m[pos] = '{it.x, it.y, it.h};
          fill++;
          expect_answer('{0, ST_OK, 1'b1});
        end
      end
      CMD_REMOVE: begin
        pos = -1;
        for (int i = 0; i < fill; i++)
          if (table_m[i].x == it.x && table_m[i].y == it.y && table_m[i].h == it.h) begin
            pos = i;
            break;
          end
        if (pos >= 0) table_m[pos].h = 0;
        expect_answer('{0, (pos >= 0) ? ST_OK : ST_NONE, 1'b1});
      end
      CMD_QUERY: begin
        for (int i = 0; i < fill; i++)
          if (table_m[i].h != 0 && near(table_m[i].x, it.x) && near(table_m[i].y, it.y)) begin
            expect_answer('{table_m[i].h, ST_OK, 1'b0});
            n++;
          end
        if (n == 0) expect_answer('{0, ST_NONE, 1'b1});
        else expected_answers[$].lst = 1'b1;
      end
      default: ;
    endcase
  endtask

  // driver: random gap before each item, hold start until accepted
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst || !driver_on) begin
      start <= 0;
    end else if (start && !busy) begin
      predict_lookup('{command, coord_x, coord_y, handle});
      start <= 0;
      gap <= $urandom_range(0, 13);
    end else if (!start) begin
      if (gap > 0) gap <= gap - 1;
      else if (pending_items.size() > 0) begin
        cmd_item_t it;
        it = pending_items.pop_front();
        command <= it.cmd;
        coord_x <= it.x;
        coord_y <= it.y;
        handle <= it.h;
        start <= 1;
      end
    end
  end

  // monitor: compare every strobed result with the oldest answer
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (found_handle !== e.h)
          report_mismatch($sformatf("handle %h want %h", found_handle, e.h));
        if (status !== e.st)
          report_mismatch($sformatf("status %0d want %0d", status, e.st));
        if (last !== e.lst)
          report_mismatch($sformatf("last %0d want %0d", last, e.lst));
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic cmd_item_t mk(logic [1:0] c, logic signed [31:0] x,
                                   logic signed [31:0] y, logic [31:0] h);
    return '{c, x, y, h};
  endfunction

  // wait until everything has come out, then some slack for silent items
  task automatic drain();
    while (!(pending_items.size() == 0 && !start && expected_answers.size() == 0))
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_tolerance(input logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    tol = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // random phase: mostly local points so queries and removes hit
  task automatic random_phase(input int count);
    cmd_item_t inserted[$];
    cmd_item_t it;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          it = mk(CMD_INSERT, rand_coord(), rand_coord(),
                  ($urandom_range(0, 7) == 0) ? 0 : $urandom);
          inserted.insert(inserted.size(), it);
        end
        4, 5: begin
          if (inserted.size() > 0 && $urandom_range(0, 3) != 0) begin
            it = inserted[$urandom_range(0, inserted.size() - 1)];
            it.cmd = CMD_REMOVE;
          end else it = mk(CMD_REMOVE, rand_coord(), rand_coord(), $urandom);
        end
        9: it = mk(CMD_UNUSED, $urandom, $urandom, $urandom);
        default: begin
          if (inserted.size() > 0 && $urandom_range(0, 3) != 0) begin
            it = inserted[$urandom_range(0, inserted.size() - 1)];
            it.x = it.x + $signed($urandom_range(0, 4 << 16)) - (2 << 16);
            it.y = it.y + $signed($urandom_range(0, 4 << 16)) - (2 << 16);
          end else it = mk(CMD_QUERY, rand_coord(), rand_coord(), $urandom);
          it.cmd = CMD_QUERY;
        end
      endcase
      queue_item(it);
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    cfg_we = 0;
    cfg_data = 0;
    command = CMD_INSERT;
    coord_x = 0;
    coord_y = 0;
    handle = 0;
    fill = 0;
    tol = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero handle, exact remove, duplicates, unused code
    set_tolerance(0);
    driver_on = 1;
    queue_item(mk(CMD_QUERY, 0, 0, 0));
    queue_item(mk(CMD_REMOVE, 0, 0, 5));
    queue_item(mk(CMD_INSERT, 32'sh7fffffff, 32'sh80000000, 32'hffffffff));
    queue_item(mk(CMD_INSERT, 32'sh80000000, 32'sh7fffffff, 32'h1));
    queue_item(mk(CMD_INSERT, 5, 5, 32'h0));
    queue_item(mk(CMD_INSERT, 5, 5, 32'haaaa5555));
    queue_item(mk(CMD_INSERT, 5, 5, 32'h5555aaaa));
    queue_item(mk(CMD_INSERT, 5, 4, 32'h77));
    queue_item(mk(CMD_QUERY, 5, 5, 0));
    queue_item(mk(CMD_REMOVE, 5, 5, 32'haaaa5555));
    queue_item(mk(CMD_REMOVE, 5, 5, 32'haaaa5555));
    queue_item(mk(CMD_QUERY, 5, 5, 32'hffffffff));
    queue_item(mk(CMD_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    queue_item(mk(CMD_QUERY, 32'sh7fffffff, 32'sh80000000, 0));
    drain();
    driver_on = 0;
    set_tolerance(31'h7fffffff);
    driver_on = 1;
    queue_item(mk(CMD_QUERY, 32'sh80000000, 32'sh80000000, 0));
    queue_item(mk(CMD_QUERY, 32'sh7fffffff, 32'sh7fffffff, 0));
    queue_item(mk(CMD_QUERY, 0, 0, 0));
    drain();

    // fill the table to overflow
    driver_on = 0;
    set_tolerance(31'h10000);
    driver_on = 1;
    random_phase(60);
    for (int i = 0; i < 70; i++)
      queue_item(mk(CMD_INSERT, rand_coord(), rand_coord(), $urandom));
    queue_item(mk(CMD_QUERY, 0, 0, 0));
    drain();

    // fresh table not possible without reset: remaining random phases run on a full table
    driver_on = 0;
    set_tolerance(31'($urandom_range(0, 31'h40000)));
    driver_on = 1;
    random_phase(60);
    drain();
    driver_on = 0;
    set_tolerance(31'($urandom));
    driver_on = 1;
    random_phase(60);
    drain();

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

[tolerance_box_point_lookup_unit.f]
+incdir+rtl
rtl/tbpl_pkg.sv
rtl/tbpl_store.sv
rtl/tbpl_seq.sv
rtl/tolerance_box_point_lookup_unit.sv
test/tolerance_box_point_lookup_unit_tb.sv
